### rtl/core/rvm_pkg.sv
package rvm_pkg;

    // Width of one velocity component (signed Q8.8).
    localparam int DATA_W = 16;

    // Components per sample: linear x, y, z, then angular x, y, z.
    localparam int NCOMP  = 6;
    localparam int COMP_W = $clog2(NCOMP);

    // Default depth of the sample ring.
    localparam int WINDOW_DEF = 8;

    // Fewest stored samples that give a valid estimate.
    localparam int MIN_VALID = 2;

    typedef logic signed [DATA_W-1:0] comp_t;

    // All six components of one sample, in component order.
    typedef logic [NCOMP-1:0][DATA_W-1:0] sample_t;

    typedef struct packed {
        logic  sample_finite;
        comp_t in_lin_x;
        comp_t in_lin_y;
        comp_t in_lin_z;
        comp_t in_ang_x;
        comp_t in_ang_y;
        comp_t in_ang_z;
    } in_word_t;

    typedef struct packed {
        logic  estimate_valid;
        comp_t med_lin_x;
        comp_t med_lin_y;
        comp_t med_lin_z;
        comp_t med_ang_x;
        comp_t med_ang_y;
        comp_t med_ang_z;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_MID,
        ST_DONE
    } rvm_state_t;

endpackage

### rtl/core/rvm_history.sv
module rvm_history #(
    parameter int WINDOW = rvm_pkg::WINDOW_DEF,
    parameter int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1,
    parameter int CNT_W  = $clog2(WINDOW + 1)
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       wr_en,
    input  rvm_pkg::sample_t                           wr_sample,
    input  logic [rvm_pkg::COMP_W-1:0]                 rd_comp,
    input  logic [IDX_W-1:0]                           rd_idx,
    output logic [WINDOW-1:0][rvm_pkg::DATA_W-1:0]     column,
    output logic [rvm_pkg::DATA_W-1:0]                 cand,
    output logic [CNT_W-1:0]                           fill
);

    // Ring of stored samples; entries at or beyond the fill count hold no sample and are masked out by the rank unit.
    logic [rvm_pkg::NCOMP-1:0][rvm_pkg::DATA_W-1:0] hist_reg [WINDOW];

    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] slot_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_reg[slot_reg] <= wr_sample;
        end
    end

    always_comb
    begin
        slot_next = slot_reg;
        fill_next = fill_reg;
        if (wr_en)
        begin
            if (slot_reg == IDX_W'(WINDOW - 1))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + IDX_W'(1);
            end
            if (fill_reg != CNT_W'(WINDOW))
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
        end
    end

    always_comb
    begin
        for (int j = 0; j < WINDOW; j++)
        begin
            column[j] = hist_reg[j][rd_comp];
        end
    end

    assign cand = hist_reg[rd_idx][rd_comp];
    assign fill = fill_reg;

endmodule

### rtl/core/rvm_rank_unit.sv
module rvm_rank_unit #(
    parameter int WINDOW = rvm_pkg::WINDOW_DEF,
    parameter int CNT_W  = $clog2(WINDOW + 1)
) (
    input  logic [WINDOW-1:0][rvm_pkg::DATA_W-1:0] column,
    input  logic [CNT_W-1:0]                       fill,
    input  logic [rvm_pkg::DATA_W-1:0]             cand,
    output logic [CNT_W-1:0]                       less_cnt,
    output logic [CNT_W-1:0]                       leq_cnt
);

    // Counts the stored values strictly below and at most equal to the candidate.
    // The candidate sits at every sorted position p with less <= p < leq.
    logic [WINDOW-1:0] lt_flag;
    logic [WINDOW-1:0] le_flag;

    always_comb
    begin
        for (int j = 0; j < WINDOW; j++)
        begin
            lt_flag[j] = (CNT_W'(j) < fill) && ($signed(column[j]) < $signed(cand));
            le_flag[j] = (CNT_W'(j) < fill) && ($signed(column[j]) <= $signed(cand));
        end
    end

    always_comb
    begin
        less_cnt = '0;
        leq_cnt  = '0;
        for (int j = 0; j < WINDOW; j++)
        begin
            less_cnt = less_cnt + CNT_W'(lt_flag[j]);
            leq_cnt  = leq_cnt + CNT_W'(le_flag[j]);
        end
    end

endmodule

### rtl/core/release_velocity_median_unit.sv
// Sliding-window median of tracked motion samples. Each input word carries a
// linear and an angular velocity vector in signed Q8.8 plus a finite flag;
// finite samples enter a ring of the last WINDOW samples, and every word,
// kept or dropped, returns one output word holding the per-component median
// of the stored samples (for an even count, the floor of the mean of the two
// middle values). With fewer than two stored samples the output word has
// estimate_valid low and all medians zero. The median is found by one shared
// rank unit that compares a candidate sample against the whole stored column
// combinationally; a small sequencer walks the n stored samples for each of
// the six components, then forms the middle-value mean. The scan is skipped
// when fewer than two samples are stored. The input is not ready while a word
// is in work; a finished word waits in the output register without blocking
// the next input word.
module release_velocity_median_unit #(
    parameter int WINDOW = rvm_pkg::WINDOW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rvm_pkg::in_word_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rvm_pkg::out_word_t out_data
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);

    rvm_pkg::rvm_state_t state_reg;
    rvm_pkg::rvm_state_t state_next;

    logic [rvm_pkg::COMP_W-1:0] comp_reg;
    logic [rvm_pkg::COMP_W-1:0] comp_next;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           idx_next;
    logic                       est_reg;
    logic                       est_next;

    // Lower and upper middle values of the current component.
    rvm_pkg::comp_t lo_reg;
    rvm_pkg::comp_t lo_next;
    rvm_pkg::comp_t hi_reg;
    rvm_pkg::comp_t hi_next;

    rvm_pkg::comp_t med_reg [rvm_pkg::NCOMP];
    logic           med_we;
    rvm_pkg::comp_t med_wdata;

    logic               out_valid_reg;
    logic               out_valid_next;
    rvm_pkg::out_word_t out_data_reg;
    rvm_pkg::out_word_t out_data_next;
    logic               out_load;

    logic                                       in_accept;
    logic                                       wr_en;
    rvm_pkg::sample_t                           wr_sample;
    logic [WINDOW-1:0][rvm_pkg::DATA_W-1:0]     column;
    logic [rvm_pkg::DATA_W-1:0]                 cand;
    logic [CNT_W-1:0]                           fill;
    logic [CNT_W-1:0]                           less_cnt;
    logic [CNT_W-1:0]                           leq_cnt;
    logic [CNT_W-1:0]                           pos_lo;
    logic [CNT_W-1:0]                           pos_hi;
    logic [rvm_pkg::DATA_W:0]                   mid_sum;

    assign in_accept = in_valid && in_ready;
    assign wr_en     = in_accept && in_data.sample_finite;

    assign wr_sample[0] = in_data.in_lin_x;
    assign wr_sample[1] = in_data.in_lin_y;
    assign wr_sample[2] = in_data.in_lin_z;
    assign wr_sample[3] = in_data.in_ang_x;
    assign wr_sample[4] = in_data.in_ang_y;
    assign wr_sample[5] = in_data.in_ang_z;

    rvm_history #(
        .WINDOW (WINDOW),
        .IDX_W  (IDX_W),
        .CNT_W  (CNT_W)
    ) u_history (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_sample (wr_sample),
        .rd_comp   (comp_reg),
        .rd_idx    (idx_reg),
        .column    (column),
        .cand      (cand),
        .fill      (fill)
    );

    rvm_rank_unit #(
        .WINDOW (WINDOW),
        .CNT_W  (CNT_W)
    ) u_rank (
        .column   (column),
        .fill     (fill),
        .cand     (cand),
        .less_cnt (less_cnt),
        .leq_cnt  (leq_cnt)
    );

    // Sorted positions of the two middle values. For an odd count both point
    // at the same element, and the mean below then returns it unchanged.
    assign pos_lo = (fill - CNT_W'(1)) >> 1;
    assign pos_hi = fill >> 1;

    // Sign-extended sum; dropping its low bit is the arithmetic right shift.
    assign mid_sum = {lo_reg[rvm_pkg::DATA_W-1], lo_reg}
                   + {hi_reg[rvm_pkg::DATA_W-1], hi_reg};

    always_comb
    begin
        state_next     = state_reg;
        comp_next      = comp_reg;
        idx_next       = idx_reg;
        est_next       = est_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        med_we         = 1'b0;
        med_wdata      = mid_sum[rvm_pkg::DATA_W:1];
        in_ready       = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            rvm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = rvm_pkg::ST_START;
                end
            end

            // The fill count now includes the newly stored sample.
            rvm_pkg::ST_START:
            begin
                comp_next = '0;
                idx_next  = '0;
                if (fill < CNT_W'(rvm_pkg::MIN_VALID))
                begin
                    est_next   = 1'b0;
                    state_next = rvm_pkg::ST_DONE;
                end
                else
                begin
                    est_next   = 1'b1;
                    state_next = rvm_pkg::ST_SCAN;
                end
            end

            rvm_pkg::ST_SCAN:
            begin
                if ((less_cnt <= pos_lo) && (leq_cnt > pos_lo))
                begin
                    lo_next = cand;
                end
                if ((less_cnt <= pos_hi) && (leq_cnt > pos_hi))
                begin
                    hi_next = cand;
                end
                if (CNT_W'(idx_reg) == fill - CNT_W'(1))
                begin
                    idx_next   = '0;
                    state_next = rvm_pkg::ST_MID;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            rvm_pkg::ST_MID:
            begin
                med_we = 1'b1;
                if (comp_reg == rvm_pkg::COMP_W'(rvm_pkg::NCOMP - 1))
                begin
                    state_next = rvm_pkg::ST_DONE;
                end
                else
                begin
                    comp_next  = comp_reg + rvm_pkg::COMP_W'(1);
                    state_next = rvm_pkg::ST_SCAN;
                end
            end

            rvm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = rvm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rvm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_data_next = out_data_reg;
        if (out_load)
        begin
            if (est_reg)
            begin
                out_data_next.estimate_valid = 1'b1;
                out_data_next.med_lin_x      = med_reg[0];
                out_data_next.med_lin_y      = med_reg[1];
                out_data_next.med_lin_z      = med_reg[2];
                out_data_next.med_ang_x      = med_reg[3];
                out_data_next.med_ang_y      = med_reg[4];
                out_data_next.med_ang_z      = med_reg[5];
            end
            else
            begin
                out_data_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rvm_pkg::ST_IDLE;
            comp_reg      <= '0;
            idx_reg       <= '0;
            est_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            comp_reg      <= comp_next;
            idx_reg       <= idx_next;
            est_reg       <= est_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        out_data_reg <= out_data_next;
        if (med_we)
        begin
            med_reg[comp_reg] <= med_wdata;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The fill count never exceeds the window depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill <= CNT_W'(WINDOW))
        else $error("fill count beyond window depth");

    // A stored sample grows a partly filled window by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (fill != CNT_W'(WINDOW))) |=> (fill == $past(fill) + CNT_W'(1)))
        else $error("fill count did not advance on a stored sample");

    // The scan only visits stored entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rvm_pkg::ST_SCAN) |-> (CNT_W'(idx_reg) < fill))
        else $error("scan index outside stored samples");

    // An output word without a valid estimate carries zero medians.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.estimate_valid) |->
            (out_data.med_lin_x == '0 && out_data.med_lin_y == '0 &&
             out_data.med_lin_z == '0 && out_data.med_ang_x == '0 &&
             out_data.med_ang_y == '0 && out_data.med_ang_z == '0))
        else $error("invalid estimate with nonzero medians");

endmodule

### dv/release_velocity_median_unit_tb.sv
module release_velocity_median_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rvm_pkg::*;

    // The block is built with its default ring depth, and the predictor uses
    // the same depth.
    localparam int WINDOW = WINDOW_DEF;

    // Half of the 12 ns clock period.
    localparam int HALF_PERIOD = 6;

    // The settle time at the end covers the processing of a word with a full
    // window, with some margin.
    localparam int END_SETTLE = 80;

    // The limit leaves plenty of room for a slow but correct run.
    localparam int CYCLE_LIMIT = 1000000;

    // Random words per traffic phase. The four phases give about 1100 words.
    localparam int ITEMS_PER_PHASE = 275;
    localparam int NUM_PHASES = 4;

    // Idle and stall percentages for each phase. The first phase has no gaps
    // at all, then the sender idles, then the receiver stalls, then both do.
    localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 60, 0, 11};
    localparam int RECV_STALL_PCT[NUM_PHASES] = '{0, 0, 60, 11};

    localparam string COMP_NAMES[NCOMP] = '{"med_lin_x", "med_lin_y", "med_lin_z",
                                            "med_ang_x", "med_ang_y", "med_ang_z"};

    // Every input starts at a known value.
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;

    // Motion words waiting to be presented, and median words that the
    // predictor expects the block to return, oldest first.
    in_word_t  motion_backlog[$];
    out_word_t expected_medians[$];

    int  words_queued   = 0;
    int  words_accepted = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  idle_pct       = 0;
    int  stall_pct      = 0;
    // Set when the word on in_data was taken at the last rising edge.
    logic in_taken      = 1'b0;

    // Predictor state: the sample ring, its write position and fill count.
    comp_t sample_ring[WINDOW][NCOMP];
    int    ring_slot    = 0;
    int    ring_fill    = 0;

    // Last random sample, used to create ties and near-ties between samples.
    comp_t last_random[NCOMP];

    release_velocity_median_unit #(
        .WINDOW   (WINDOW)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    initial
    begin
        forever
        begin
            #HALF_PERIOD clk = ~clk;
        end
    end

    // Stores a finite sample in the ring and returns the median word that the
    // block must produce for this input word. Dropped samples leave the ring
    // untouched but still produce a word.
    function automatic out_word_t median_after(in_word_t w);
        comp_t     incoming[NCOMP];
        comp_t     column[WINDOW];
        comp_t     medians[NCOMP];
        comp_t     key;
        int        j;
        int        mid;
        out_word_t result;
        incoming = '{w.in_lin_x, w.in_lin_y, w.in_lin_z,
                     w.in_ang_x, w.in_ang_y, w.in_ang_z};
        if (w.sample_finite)
        begin
            sample_ring[ring_slot] = incoming;
            ring_slot = (ring_slot + 1) % WINDOW;
            if (ring_fill < WINDOW)
                ring_fill++;
        end
        result = '0;
        if (ring_fill < MIN_VALID)
            return result;
        // The ring is unordered, so each column is sorted on its own.
        for (int c = 0; c < NCOMP; c++)
        begin
            for (int i = 0; i < ring_fill; i++)
                column[i] = sample_ring[i][c];
            for (int i = 1; i < ring_fill; i++)
            begin
                key = column[i];
                j = i;
                while (j > 0 && column[j-1] > key)
                begin
                    column[j] = column[j-1];
                    j--;
                end
                column[j] = key;
            end
            mid = ring_fill / 2;
            // An even count takes the floor of the mean of the two middle
            // values. The 32-bit sum cannot overflow.
            if (ring_fill % 2 == 1)
                medians[c] = column[mid];
            else
                medians[c] = comp_t'((int'(column[mid-1]) + int'(column[mid])) >>> 1);
        end
        result = {1'b1, medians[0], medians[1], medians[2],
                  medians[3], medians[4], medians[5]};
        return result;
    endfunction

    function automatic in_word_t motion_word(bit finite, int lx, int ly, int lz,
                                             int ax, int ay, int az);
        in_word_t w;
        w.sample_finite = finite;
        w.in_lin_x = comp_t'(lx);
        w.in_lin_y = comp_t'(ly);
        w.in_lin_z = comp_t'(lz);
        w.in_ang_x = comp_t'(ax);
        w.in_ang_y = comp_t'(ay);
        w.in_ang_z = comp_t'(az);
        return w;
    endfunction

    // Picks one component. The mix favors values that stress the sort and the
    // mean: full-range noise, small values near zero, the extremes of Q8.8,
    // exact ties with the previous sample and near-ties.
    function automatic comp_t pick_component(comp_t prior);
        case ($urandom_range(4))
            0: return comp_t'($urandom);
            1: return comp_t'(int'($urandom_range(512)) - 256);
            2:
            begin
                case ($urandom_range(3))
                    0: return comp_t'(16'h7FFF);
                    1: return comp_t'(16'h8000);
                    2: return comp_t'(16'hFFFF);
                    default: return comp_t'(16'h7FFE);
                endcase
            end
            3: return prior;
            default: return comp_t'(int'(prior) + int'($urandom_range(6)) - 3);
        endcase
    endfunction

    // About one word in eight carries a non-finite sample and is dropped.
    function automatic in_word_t random_motion_word();
        comp_t picked[NCOMP];
        bit    finite;
        finite = ($urandom_range(99) >= 12);
        for (int c = 0; c < NCOMP; c++)
            picked[c] = pick_component(last_random[c]);
        if (finite)
            last_random = picked;
        return motion_word(finite, picked[0], picked[1], picked[2],
                           picked[3], picked[4], picked[5]);
    endfunction

    task automatic queue_word(in_word_t w);
        motion_backlog.push_back(w);
        words_queued++;
    endtask

    // Directed words: a dropped word on an empty ring, a single stored sample,
    // a drop at a count of one, two samples at the extremes of Q8.8 so that
    // the middle-value mean must not overflow and must round toward minus
    // infinity, odd counts, a drop once the estimate is valid, then enough
    // samples to fill the ring and wrap its write position.
    task automatic queue_directed_words();
        queue_word(motion_word(1'b0, 4660, -4660, 1, -1, 32767, -32768));
        queue_word(motion_word(1'b1, 32767, -32768, 32767, -1, 1, -3));
        queue_word(motion_word(1'b0, -32768, 32767, 0, 0, 0, 0));
        queue_word(motion_word(1'b1, 32767, -32768, -32768, 0, 2, 0));
        queue_word(motion_word(1'b1, 0, 0, 0, 0, 0, 0));
        queue_word(motion_word(1'b0, 32767, 32767, 32767, 32767, 32767, 32767));
        for (int k = 0; k < 10; k++)
            queue_word(motion_word(k != 6, 32767 - k * 6000, -32768 + k * 3,
                                   (k % 2 == 1) ? 32767 : -32768, k - 4, 100,
                                   -k * k * 300));
    endtask

    // Compares one output word with the oldest expected median word, field by
    // field. Unknown bits in the output count as a mismatch.
    task automatic check_median_word(out_word_t want, out_word_t got);
        sample_t want_comps;
        sample_t got_comps;
        bit      bad;
        want_comps = sample_t'(want[NCOMP*DATA_W-1:0]);
        got_comps  = sample_t'(got[NCOMP*DATA_W-1:0]);
        bad = (want !== got);
        if (!bad)
            return;
        mismatch_count++;
        if (want.estimate_valid !== got.estimate_valid)
            $error("estimate_valid: expected %0d, got %0d",
                   want.estimate_valid, got.estimate_valid);
        // The first component sits in the most significant slice.
        for (int c = 0; c < NCOMP; c++)
            if (want_comps[NCOMP-1-c] !== got_comps[NCOMP-1-c])
                $error("%s: expected %0d, got %0d", COMP_NAMES[c],
                       $signed(want_comps[NCOMP-1-c]), $signed(got_comps[NCOMP-1-c]));
    endtask

    // Driver. It works on the falling edge. A new word is presented only when
    // the line is free or the word on it was taken at the last rising edge,
    // so in_valid is assigned once per edge and stays high across
    // back-to-back words. The receiver's ready is redrawn every cycle.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
        if (!in_valid || in_taken)
        begin
            if (motion_backlog.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= motion_backlog.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor. It samples both handshakes at the rising edge. The output word
    // is checked before the accepted input word is predicted; a word's result
    // passes through the START and DONE states before it reaches the output
    // register, so a word and its own result never meet at one edge.
    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_medians.size() == 0)
                begin
                    mismatch_count++;
                    $error("median word arrived with none expected");
                end
                else
                begin
                    check_median_word(expected_medians.pop_front(), out_data);
                end
            end
            if (in_valid && in_ready)
            begin
                expected_medians.push_back(median_after(in_data));
                words_accepted <= words_accepted + 1;
            end
        end
    end

    // Watchdog for a block that hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        for (int c = 0; c < NCOMP; c++)
            last_random[c] = '0;
        // Reset is released on a falling edge, away from the rising edges at which
        // the block samples.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Each phase queues its words and then waits until every word has
        // been taken and every expected median word has come back.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            idle_pct  = SEND_IDLE_PCT[p];
            stall_pct = RECV_STALL_PCT[p];
            if (p == 0)
                queue_directed_words();
            repeat (ITEMS_PER_PHASE) queue_word(random_motion_word());
            while (words_accepted != words_queued || expected_medians.size() != 0)
                @(posedge clk);
        end

        // Let any stray output word show up before the verdict.
        repeat (END_SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/rvm_pkg.sv
rtl/core/rvm_history.sv
rtl/core/rvm_rank_unit.sv
rtl/core/release_velocity_median_unit.sv
dv/release_velocity_median_unit_tb.sv
